// File: sv/fresnel_zone_radius_assert.svh
// Assertion macros for the Fresnel zone radius block
`ifndef FRESNEL_ZONE_RADIUS_ASSERT_SVH
`define FRESNEL_ZONE_RADIUS_ASSERT_SVH

`ifndef SYNTHESIS

`define FZR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fzr assertion failed");

`define FZR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fzr assertion failed");

`else

`define FZR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FZR_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: sv/fzr_pkg.sv
package fzr_pkg;

    localparam int DW    = 20;
    localparam int FW    = 16;
    localparam int FRAC  = 16;
    localparam int NW    = 2 * DW;
    localparam int DENW  = DW + FW;
    localparam int QW    = DW + 14;
    localparam int RW    = (QW + 1) / 2;
    localparam int SQW   = 2 * RW;
    localparam int ZW    = 22;
    localparam int CW    = 13;
    localparam int PW    = RW + CW;
    localparam int RADIUS_SHIFT = 8;
    localparam int SHW   = PW - RADIUS_SHIFT;
    localparam int XW    = (SHW > ZW) ? SHW : ZW;
    localparam int CFG_IW = 1;

    localparam logic [CW-1:0] RADIUS_COEF = CW'(4429);
    localparam logic [ZW-1:0] ZONE_MAX    = '1;
    localparam logic [FW-1:0] FREQ_RESET  = FW'(1000);

    localparam logic [CFG_IW-1:0] CFG_PATH_LEN = CFG_IW'(0);
    localparam logic [CFG_IW-1:0] CFG_FREQ     = CFG_IW'(1);

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BEYOND = 2'd1,
        ST_NOPATH = 2'd2
    } t_status;

    // item details carried alongside the arithmetic
    typedef struct packed {
        logic [DW-1:0] pt_dist;
        logic          last;
        t_status       status;
    } t_side;

    typedef struct packed {
        logic [DW-1:0] pt_dist;
        logic [ZW-1:0] radius;
        t_status       status;
        logic          last;
    } t_res;

endpackage

// File: sv/fzr_pt_if.sv
interface fzr_pt_if;
    logic                     valid;
    logic                     ready;
    logic [fzr_pkg::DW-1:0]   point_distance;
    logic                     last_point;

    modport source (output valid, output point_distance, output last_point, input ready);
    modport sink   (input valid, input point_distance, input last_point, output ready);
endinterface

// File: sv/fzr_res_if.sv
interface fzr_res_if;
    logic                     valid;
    logic                     ready;
    logic [fzr_pkg::DW-1:0]   point_distance_out;
    logic [fzr_pkg::ZW-1:0]   zone_radius;
    logic [1:0]               status;
    logic                     last_point_out;

    modport source (output valid, output point_distance_out, output zone_radius,
                    output status, output last_point_out, input ready);
    modport sink   (input valid, input point_distance_out, input zone_radius,
                    input status, input last_point_out, output ready);
endinterface

// File: sv/fzr_div.sv
`include "fresnel_zone_radius_assert.svh"

// restoring divider, one quotient bit per stage: quo = (num << FRAC) / den
module fzr_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [fzr_pkg::NW-1:0]     i_num,
    input  logic [fzr_pkg::DENW-1:0]   i_den,
    input  fzr_pkg::t_side             i_side,
    output logic                       o_valid,
    output logic [fzr_pkg::QW-1:0]     o_quo,
    output fzr_pkg::t_side             o_side
);
    localparam int QW   = fzr_pkg::QW;
    localparam int DENW = fzr_pkg::DENW;
    localparam int LEN  = fzr_pkg::NW + fzr_pkg::FRAC;

    logic [LEN-1:0]  dvd;
    logic            w_v    [QW+1];
    logic [DENW-1:0] w_rem  [QW+1];
    logic [QW-1:0]   w_lo   [QW+1];
    logic [QW-1:0]   w_quo  [QW+1];
    logic [DENW-1:0] w_den  [QW+1];
    fzr_pkg::t_side  w_side [QW+1];

    assign dvd       = {i_num, {fzr_pkg::FRAC{1'b0}}};
    assign w_v[0]    = i_valid;
    assign w_rem[0]  = DENW'(dvd[LEN-1:QW]);
    assign w_lo[0]   = dvd[QW-1:0];
    assign w_quo[0]  = '0;
    assign w_den[0]  = i_den;
    assign w_side[0] = i_side;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic            r_v;
        logic [DENW-1:0] r_rem;
        logic [QW-1:0]   r_lo;
        logic [QW-1:0]   r_quo;
        logic [DENW-1:0] r_den;
        fzr_pkg::t_side  r_side;
        logic [DENW:0]   tr;
        logic [DENW:0]   df;
        logic            ge;
        logic [DENW-1:0] n_rem;

        assign tr    = {w_rem[k], w_lo[k][QW-1]};
        assign ge    = tr >= {1'b0, w_den[k]};
        assign df    = tr - {1'b0, w_den[k]};
        assign n_rem = ge ? df[DENW-1:0] : tr[DENW-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= n_rem;
                r_lo   <= {w_lo[k][QW-2:0], 1'b0};
                r_quo  <= {w_quo[k][QW-2:0], ge};
                r_den  <= w_den[k];
                r_side <= w_side[k];
            end
        end

        assign w_v[k+1]    = r_v;
        assign w_rem[k+1]  = r_rem;
        assign w_lo[k+1]   = r_lo;
        assign w_quo[k+1]  = r_quo;
        assign w_den[k+1]  = r_den;
        assign w_side[k+1] = r_side;
    end

    assign o_valid = w_v[QW];
    assign o_quo   = w_quo[QW];
    assign o_side  = w_side[QW];

    `FZR_ASSERT_IMP(a_div_rem_below_den, i_clk, i_rst_n, w_v[QW], w_rem[QW] < w_den[QW])

endmodule

// File: sv/fzr_sqrt.sv
`include "fresnel_zone_radius_assert.svh"

// digit-by-digit integer square root, one root bit per stage
module fzr_sqrt (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [fzr_pkg::QW-1:0]   i_val,
    input  fzr_pkg::t_side           i_side,
    output logic                     o_valid,
    output logic [fzr_pkg::RW-1:0]   o_root,
    output fzr_pkg::t_side           o_side
);
    localparam int RW  = fzr_pkg::RW;
    localparam int SQW = fzr_pkg::SQW;

    logic            w_v    [RW+1];
    logic [RW:0]     w_rem  [RW+1];
    logic [RW-1:0]   w_root [RW+1];
    logic [SQW-1:0]  w_x    [RW+1];
    fzr_pkg::t_side  w_side [RW+1];

    assign w_v[0]    = i_valid;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_x[0]    = SQW'(i_val);
    assign w_side[0] = i_side;

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic            r_v;
        logic [RW:0]     r_rem;
        logic [RW-1:0]   r_root;
        logic [SQW-1:0]  r_x;
        fzr_pkg::t_side  r_side;
        logic [RW+2:0]   tr;
        logic [RW+2:0]   trial;
        logic            ge;
        logic [RW+2:0]   df;

        assign tr    = {w_rem[k], w_x[k][SQW-1:SQW-2]};
        assign trial = {1'b0, w_root[k], 2'b01};
        assign ge    = tr >= trial;
        assign df    = ge ? (tr - trial) : tr;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= df[RW:0];
                r_root <= {w_root[k][RW-2:0], ge};
                r_x    <= {w_x[k][SQW-3:0], 2'b00};
                r_side <= w_side[k];
            end
        end

        assign w_v[k+1]    = r_v;
        assign w_rem[k+1]  = r_rem;
        assign w_root[k+1] = r_root;
        assign w_x[k+1]    = r_x;
        assign w_side[k+1] = r_side;
    end

    assign o_valid = w_v[RW];
    assign o_root  = w_root[RW];
    assign o_side  = w_side[RW];

    `FZR_ASSERT_IMP(a_sqrt_rem_bound, i_clk, i_rst_n, w_v[RW], w_rem[RW] <= {w_root[RW], 1'b0})

endmodule

// File: sv/fresnel_zone_radius.sv
// Path from accept to result: stages A and B, divider, square root, stage C, output register.
// Throughput: one item per cycle while the skid is empty; divider takes one quotient bit
// per stage, square root one root bit per stage.
// An output register plus a skid register; the pipeline halts only while the skid holds an item.
// Reset (synchronous, active low): clears all valid bits, path_length 0, frequency_mhz 1000.
`include "fresnel_zone_radius_assert.svh"

module fresnel_zone_radius (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [fzr_pkg::CFG_IW-1:0]        i_cfg_idx,
    input  logic [fzr_pkg::DW-1:0]            i_cfg_data,
    fzr_pt_if.sink                            i_pt,
    fzr_res_if.source                         o_res
);
    localparam int DW   = fzr_pkg::DW;
    localparam int FW   = fzr_pkg::FW;
    localparam int NW   = fzr_pkg::NW;
    localparam int DENW = fzr_pkg::DENW;
    localparam int QW   = fzr_pkg::QW;
    localparam int RW   = fzr_pkg::RW;
    localparam int PW   = fzr_pkg::PW;
    localparam int SHW  = fzr_pkg::SHW;
    localparam int XW   = fzr_pkg::XW;

    logic [DW-1:0] r_path_len;
    logic [FW-1:0] r_freq;

    logic            en;
    logic            take;
    logic            c_push;
    logic            bad_out;

    // stage A: classify, select multiplier operands
    fzr_pkg::t_status st;
    logic [FW-1:0]   f_eff;
    logic            pt_ok;
    logic            r_a_v;
    logic [DW-1:0]   r_a_m1;
    logic [DW-1:0]   r_a_m2;
    logic [DW-1:0]   r_a_dd;
    logic [FW-1:0]   r_a_f;
    fzr_pkg::t_side  r_a_side;

    // stage B: products
    logic            r_b_v;
    logic [NW-1:0]   r_b_num;
    logic [DENW-1:0] r_b_den;
    fzr_pkg::t_side  r_b_side;
    logic [NW-1:0]   n_num;
    logic [DENW-1:0] n_den;

    logic            div_v;
    logic [QW-1:0]   div_quo;
    fzr_pkg::t_side  div_side;

    logic            sq_v;
    logic [RW-1:0]   sq_root;
    fzr_pkg::t_side  sq_side;

    // stage C: scale by 17.3
    logic            r_c_v;
    logic [PW-1:0]   r_c_prod;
    fzr_pkg::t_side  r_c_side;
    logic [PW-1:0]   n_prod;

    logic [SHW-1:0]  sh;
    logic [XW-1:0]   sh_ext;
    fzr_pkg::t_res   tail;

    logic            r_out_v;
    fzr_pkg::t_res   r_out;
    logic            r_skid_v;
    fzr_pkg::t_res   r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_path_len <= '0;
            r_freq     <= fzr_pkg::FREQ_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fzr_pkg::CFG_PATH_LEN: r_path_len <= i_cfg_data;
                fzr_pkg::CFG_FREQ:     r_freq     <= i_cfg_data[FW-1:0];
                default: ;
            endcase
        end
    end

    assign en         = !r_skid_v;
    assign i_pt.ready = en;

    always_comb begin
        f_eff = (r_freq == '0) ? FW'(1) : r_freq;
        if (r_path_len == '0) begin
            st = fzr_pkg::ST_NOPATH;
        end else if (i_pt.point_distance > r_path_len) begin
            st = fzr_pkg::ST_BEYOND;
        end else begin
            st = fzr_pkg::ST_OK;
        end
        pt_ok = (st == fzr_pkg::ST_OK);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else if (en) begin
            r_a_v <= i_pt.valid;
            r_b_v <= r_a_v;
            r_c_v <= sq_v;
        end
    end

    assign n_num  = r_a_m1 * r_a_m2;
    assign n_den  = r_a_f * r_a_dd;
    assign n_prod = sq_root * fzr_pkg::RADIUS_COEF;

    // out-of-range points divide zero by f so the quotient comes out zero
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_m1           <= pt_ok ? i_pt.point_distance : '0;
            r_a_m2           <= pt_ok ? (r_path_len - i_pt.point_distance) : '0;
            r_a_dd           <= pt_ok ? r_path_len : DW'(1);
            r_a_f            <= f_eff;
            r_a_side.pt_dist <= i_pt.point_distance;
            r_a_side.last    <= i_pt.last_point;
            r_a_side.status  <= st;
            r_b_num          <= n_num;
            r_b_den          <= n_den;
            r_b_side         <= r_a_side;
            r_c_prod         <= n_prod;
            r_c_side         <= sq_side;
        end
    end

    fzr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_b_v),
        .i_num   (r_b_num),
        .i_den   (r_b_den),
        .i_side  (r_b_side),
        .o_valid (div_v),
        .o_quo   (div_quo),
        .o_side  (div_side)
    );

    fzr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (div_v),
        .i_val   (div_quo),
        .i_side  (div_side),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    always_comb begin
        sh           = r_c_prod[PW-1:fzr_pkg::RADIUS_SHIFT];
        sh_ext       = XW'(sh);
        tail.pt_dist = r_c_side.pt_dist;
        tail.status  = r_c_side.status;
        tail.last    = r_c_side.last;
        if (sh_ext > XW'(fzr_pkg::ZONE_MAX)) begin
            tail.radius = fzr_pkg::ZONE_MAX;
        end else begin
            tail.radius = sh_ext[fzr_pkg::ZW-1:0];
        end
    end

    assign take    = !r_out_v || o_res.ready;
    assign c_push  = en && r_c_v;
    assign bad_out = r_out_v && (r_out.status != fzr_pkg::ST_OK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (take) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_out    <= r_skid;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= c_push;
                r_out    <= tail;
            end
        end else if (c_push) begin
            r_skid_v <= 1'b1;
            r_skid   <= tail;
        end
    end

    assign o_res.valid              = r_out_v;
    assign o_res.point_distance_out = r_out.pt_dist;
    assign o_res.zone_radius        = r_out.radius;
    assign o_res.status             = r_out.status;
    assign o_res.last_point_out     = r_out.last;

    `FZR_ASSERT_IMP(a_skid_needs_out, i_clk, i_rst_n, r_skid_v, r_out_v)
    `FZR_ASSERT_NXT(a_stall_fills_skid, i_clk, i_rst_n, !take && c_push, r_skid_v)
    `FZR_ASSERT_IMP(a_bad_point_zero, i_clk, i_rst_n, bad_out, r_out.radius == '0)

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW     = fzr_pkg::DW;
    localparam int FW     = fzr_pkg::FW;
    localparam int ZW     = fzr_pkg::ZW;
    localparam int CFG_IW = fzr_pkg::CFG_IW;
    localparam int PIPE_DEPTH = 2 + fzr_pkg::QW + fzr_pkg::RW + 2;
    localparam int HOLD_CYCLES = 400;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    // data is the point distance on item rows, the register word on config rows
    typedef struct {
        t_row_kind         kind;
        logic [CFG_IW-1:0] idx;
        logic [DW-1:0]     data;
        logic              last;
        logic              typed;
        logic [ZW-1:0]     radius;
        fzr_pkg::t_status  status;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IW-1:0] i_cfg_idx;
    logic [DW-1:0] i_cfg_data;

    fzr_pt_if  pt_ch ();
    fzr_res_if res_ch ();

    fresnel_zone_radius uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pt       (pt_ch.sink),
        .o_res      (res_ch.source)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    logic [DW-1:0]  path_len_cfg;
    logic [FW-1:0]  freq_cfg;
    fzr_pkg::t_res  radius_expected [$];
    int             mismatches = 0;
    logic           no_gaps = 1'b0;
    int             hold_seq = 0;

    t_row dir_rows [$] = '{
        '{ROW_ITEM, fzr_pkg::CFG_PATH_LEN, 20'd0,      1'b0, 1'b1, '0, fzr_pkg::ST_NOPATH},
        '{ROW_ITEM, fzr_pkg::CFG_PATH_LEN, 20'hFFFFF,  1'b1, 1'b1, '0, fzr_pkg::ST_NOPATH},
        '{ROW_CFG,  fzr_pkg::CFG_PATH_LEN, 20'd1000,   1'b0, 1'b0, '0, fzr_pkg::ST_OK},
        '{ROW_CFG,  fzr_pkg::CFG_FREQ,     20'd1000,   1'b0, 1'b0, '0, fzr_pkg::ST_OK},
        '{ROW_ITEM, fzr_pkg::CFG_PATH_LEN, 20'd0,      1'b0, 1'b1, '0, fzr_pkg::ST_OK},
        '{ROW_ITEM, fzr_pkg::CFG_PATH_LEN, 20'd1000,   1'b1, 1'b1, '0, fzr_pkg::ST_OK},
        '{ROW_ITEM, fzr_pkg::CFG_PATH_LEN, 20'd1001,   1'b0, 1'b1, '0, fzr_pkg::ST_BEYOND},
        '{ROW_ITEM, fzr_pkg::CFG_PATH_LEN, 20'hFFFFF,  1'b0, 1'b1, '0, fzr_pkg::ST_BEYOND},
        '{ROW_ITEM, fzr_pkg::CFG_PATH_LEN, 20'd500,    1'b0, 1'b0, '0, fzr_pkg::ST_OK},
        '{ROW_ITEM, fzr_pkg::CFG_PATH_LEN, 20'd1,      1'b1, 1'b0, '0, fzr_pkg::ST_OK},
        '{ROW_ITEM, fzr_pkg::CFG_PATH_LEN, 20'd999,    1'b0, 1'b0, '0, fzr_pkg::ST_OK},
        '{ROW_CFG,  fzr_pkg::CFG_PATH_LEN, 20'hFFFFF,  1'b0, 1'b0, '0, fzr_pkg::ST_OK},
        // zero frequency, upper data bits set and dropped
        '{ROW_CFG,  fzr_pkg::CFG_FREQ,     20'hF0000,  1'b0, 1'b0, '0, fzr_pkg::ST_OK},
        '{ROW_ITEM, fzr_pkg::CFG_PATH_LEN, 20'd524287, 1'b0, 1'b0, '0, fzr_pkg::ST_OK},
        '{ROW_ITEM, fzr_pkg::CFG_PATH_LEN, 20'd524288, 1'b1, 1'b0, '0, fzr_pkg::ST_OK},
        '{ROW_ITEM, fzr_pkg::CFG_PATH_LEN, 20'd1,      1'b0, 1'b0, '0, fzr_pkg::ST_OK},
        '{ROW_ITEM, fzr_pkg::CFG_PATH_LEN, 20'hFFFFE,  1'b0, 1'b0, '0, fzr_pkg::ST_OK},
        '{ROW_ITEM, fzr_pkg::CFG_PATH_LEN, 20'hFFFFF,  1'b1, 1'b1, '0, fzr_pkg::ST_OK},
        '{ROW_CFG,  fzr_pkg::CFG_FREQ,     20'h0FFFF,  1'b0, 1'b0, '0, fzr_pkg::ST_OK},
        '{ROW_ITEM, fzr_pkg::CFG_PATH_LEN, 20'd524288, 1'b0, 1'b0, '0, fzr_pkg::ST_OK},
        '{ROW_ITEM, fzr_pkg::CFG_PATH_LEN, 20'd12345,  1'b0, 1'b0, '0, fzr_pkg::ST_OK},
        '{ROW_CFG,  fzr_pkg::CFG_PATH_LEN, 20'd1,      1'b0, 1'b0, '0, fzr_pkg::ST_OK},
        '{ROW_ITEM, fzr_pkg::CFG_PATH_LEN, 20'd0,      1'b0, 1'b1, '0, fzr_pkg::ST_OK},
        '{ROW_ITEM, fzr_pkg::CFG_PATH_LEN, 20'd1,      1'b1, 1'b1, '0, fzr_pkg::ST_OK},
        '{ROW_ITEM, fzr_pkg::CFG_PATH_LEN, 20'd2,      1'b0, 1'b1, '0, fzr_pkg::ST_BEYOND}
    };

    function automatic fzr_pkg::t_res fresnel_predict(input logic [DW-1:0] d1, input logic lst);
        fzr_pkg::t_res r;
        logic [FW-1:0] f;
        logic [63:0]   num;
        logic [63:0]   den;
        logic [63:0]   q;
        logic [63:0]   root;
        logic [63:0]   trial;
        logic [63:0]   scaled;
        r.pt_dist = d1;
        r.last    = lst;
        r.radius  = '0;
        r.status  = fzr_pkg::ST_OK;
        f = (freq_cfg == '0) ? FW'(1) : freq_cfg;
        if (path_len_cfg == '0) begin
            r.status = fzr_pkg::ST_NOPATH;
        end else if (d1 > path_len_cfg) begin
            r.status = fzr_pkg::ST_BEYOND;
        end else begin
            num  = (64'(d1) * 64'(path_len_cfg - d1)) << fzr_pkg::FRAC;
            den  = 64'(f) * 64'(path_len_cfg);
            q    = num / den;
            root = '0;
            for (int b = 31; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= q)
                    root = trial;
            end
            scaled   = (root * 64'(fzr_pkg::RADIUS_COEF)) >> fzr_pkg::RADIUS_SHIFT;
            r.radius = (scaled > 64'(fzr_pkg::ZONE_MAX)) ? fzr_pkg::ZONE_MAX : scaled[ZW-1:0];
        end
        return r;
    endfunction

    function automatic logic [DW-1:0] pick_point(input logic [DW-1:0] len);
        case ($urandom_range(11))
            0: return '0;
            1: return len;
            2: return len + 1'b1;
            3: return DW'($urandom);
            4: return len >> 1;
            default: return (len == '0) ? DW'($urandom) : DW'($urandom_range(len));
        endcase
    endfunction

    task automatic send_point(input logic [DW-1:0] d, input logic lst,
                              input fzr_pkg::t_res exp);
        while (!no_gaps && $urandom_range(99) < 34) begin
            pt_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pt_ch.valid          <= 1'b1;
        pt_ch.point_distance <= d;
        pt_ch.last_point     <= lst;
        do
            @(posedge i_clk);
        while (!pt_ch.ready);
        radius_expected = {radius_expected, exp};
    endtask

    task automatic drain_results();
        pt_ch.valid <= 1'b0;
        while (radius_expected.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [DW-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == fzr_pkg::CFG_PATH_LEN)
            path_len_cfg = data;
        else if (idx == fzr_pkg::CFG_FREQ)
            freq_cfg = data[FW-1:0];
        @(posedge i_clk);
    endtask

    task automatic run_profile(input int n_pts, input logic [DW-1:0] len,
                               input logic [DW-1:0] freq_word);
        logic [DW-1:0] d;
        logic          lst;
        drain_results();
        write_reg(fzr_pkg::CFG_PATH_LEN, len);
        write_reg(fzr_pkg::CFG_FREQ, freq_word);
        repeat (n_pts) begin
            d   = pick_point(path_len_cfg);
            lst = ($urandom_range(7) == 0);
            send_point(d, lst, fresnel_predict(d, lst));
        end
    endtask

    task automatic check_result();
        fzr_pkg::t_res exp;
        if (radius_expected.size() == 0) begin
            $display("%0t: unexpected result, dist %0d radius %0d", $time,
                     res_ch.point_distance_out, res_ch.zone_radius);
            mismatches++;
            return;
        end
        exp = radius_expected.pop_front();
        if (res_ch.point_distance_out !== exp.pt_dist) begin
            $display("%0t: point_distance_out expected %0d got %0d", $time,
                     exp.pt_dist, res_ch.point_distance_out);
            mismatches++;
        end
        if (res_ch.zone_radius !== exp.radius) begin
            $display("%0t: zone_radius (dist %0d) expected %0d got %0d", $time,
                     exp.pt_dist, exp.radius, res_ch.zone_radius);
            mismatches++;
        end
        if (res_ch.status !== exp.status) begin
            $display("%0t: status (dist %0d) expected %0d got %0d", $time,
                     exp.pt_dist, exp.status, res_ch.status);
            mismatches++;
        end
        if (res_ch.last_point_out !== exp.last) begin
            $display("%0t: last_point_out expected %0d got %0d", $time,
                     exp.last, res_ch.last_point_out);
            mismatches++;
        end
    endtask

    initial begin : result_sink
        int hold_left;
        int seen_seq;
        hold_left = 0;
        seen_seq  = 0;
        res_ch.ready <= 1'b0;
        do
            @(posedge i_clk);
        while (!i_rst_n);
        forever begin
            @(posedge i_clk);
            if (res_ch.valid && res_ch.ready)
                check_result();
            if (hold_seq != seen_seq) begin
                seen_seq  = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= no_gaps || ($urandom_range(99) >= 34);
            end
        end
    end

    initial begin : point_source
        fzr_pkg::t_res exp;
        path_len_cfg = '0;
        freq_cfg     = fzr_pkg::FREQ_RESET;
        i_rst_n              <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_idx            <= fzr_pkg::CFG_PATH_LEN;
        i_cfg_data           <= '0;
        pt_ch.valid          <= 1'b0;
        pt_ch.point_distance <= '0;
        pt_ch.last_point     <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                drain_results();
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            end else begin
                if (dir_rows[i].typed) begin
                    exp.pt_dist = dir_rows[i].data;
                    exp.radius  = dir_rows[i].radius;
                    exp.status  = dir_rows[i].status;
                    exp.last    = dir_rows[i].last;
                end else begin
                    exp = fresnel_predict(dir_rows[i].data, dir_rows[i].last);
                end
                send_point(dir_rows[i].data, dir_rows[i].last, exp);
            end
        end

        run_profile(200, DW'($urandom_range(2, 20'hFFFFF)), DW'($urandom_range(1, 20'hFFFFF)));
        drain_results();
        no_gaps <= 1'b1;
        run_profile(200, 20'hFFFFF, {4'($urandom), 16'h0000});
        drain_results();
        no_gaps <= 1'b0;
        run_profile(150, 20'd1, 20'h0FFFF);
        // receiver held off while points keep coming, so the pipeline backs up
        drain_results();
        hold_seq <= hold_seq + 1;
        run_profile(200, DW'($urandom_range(1, 1000)), DW'($urandom));
        run_profile(100, 20'd0, DW'($urandom));
        run_profile(200, DW'($urandom), 20'd1);
        run_profile(150, DW'($urandom_range(1, 20'hFFFFF)), DW'($urandom_range(1, 20'hFFFF)));

        drain_results();
        repeat (PIPE_DEPTH + 10) @(posedge i_clk);
        if (mismatches == 0 && radius_expected.size() == 0) begin
            $display("fresnel_zone_radius regression: pass");
        end else begin
            $display("fresnel_zone_radius regression: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("fresnel_zone_radius regression: fail");
        $finish;
    end

endmodule

// File: fresnel_zone_radius.f
+incdir+sv
sv/fzr_pkg.sv
sv/fzr_pt_if.sv
sv/fzr_res_if.sv
sv/fzr_div.sv
sv/fzr_sqrt.sv
sv/fresnel_zone_radius.sv
tb/sv/tb_top.sv
